[design/dlelk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlelk_pkg
// Shared constants, command codes and queue entry types of the DLE link engine.
// ----------------------------------------------------------------------------
package dlelk_pkg;

  localparam int unsigned RX_DEPTH  = 64;
  localparam int unsigned MSG_LEN   = 6;
  localparam int unsigned PAY_BYTES = 6;
  localparam int unsigned PAY_W     = 8 * PAY_BYTES;
  localparam int unsigned WIDX_W    = $clog2(RX_DEPTH + 1);
  localparam int unsigned STEP_W    = $clog2(MSG_LEN + 4);
  localparam int unsigned MSG_IDX_W = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_DLE  = 8'h10;
  localparam logic [7:0] CH_ENQ  = 8'h05;
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_ETB  = 8'h17;
  localparam logic [7:0] CH_ACK0 = 8'h06;
  localparam logic [7:0] CH_ACK1 = 8'h08;

  localparam logic [PAY_W-1:0] TX_PAYLOAD_RST = 48'h216F6C6C6548;

  localparam logic [STEP_W-1:0] STEP_MSG     = STEP_W'(MSG_LEN);
  localparam logic [STEP_W-1:0] STEP_MSG_P2  = STEP_W'(MSG_LEN + 2);
  localparam logic [STEP_W-1:0] LAST_SHORT   = STEP_W'(1);
  localparam logic [STEP_W-1:0] LAST_DELIVER = STEP_W'(MSG_LEN + 1);
  localparam logic [STEP_W-1:0] LAST_SEND    = STEP_W'(MSG_LEN + 3);

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ENQ,
    CMD_ETB,
    CMD_ACK0
  } cmd_e;

  typedef logic [MSG_LEN-1:0][7:0] msg_t;

  typedef struct packed {
    cmd_e cmd;
    msg_t msg;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  // index of the final reply byte for a command
  function automatic logic [STEP_W-1:0] cmd_last_step(input cmd_e cmd);
    logic [STEP_W-1:0] r;
    case (cmd)
      CMD_ETB:  r = LAST_DELIVER;
      CMD_ACK0: r = LAST_SEND;
      default:  r = LAST_SHORT;
    endcase
    return r;
  endfunction

endpackage

[design/dlelk_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlelk_if
// Valid/ready channels of the DLE link engine: input items and result items.
// ----------------------------------------------------------------------------
interface dlelk_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface dlelk_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_kind, output out_byte, output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

[design/dlelk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlelk_front
// Escape decoder and receive store; turns items that need a reply into commands.
// ----------------------------------------------------------------------------
module dlelk_front import dlelk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlelk_in_if.sink  in_i,
  output q_port_t   push_o,
  input  logic      full_i
);

  logic              esc_q, esc_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  msg_t              msg_q, msg_d;
  logic              accept;
  logic              store;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    esc_d              = esc_q;
    widx_d             = widx_q;
    msg_d              = msg_q;
    store              = 1'b0;
    push_o.valid       = 1'b0;
    push_o.entry.cmd   = CMD_START;
    push_o.entry.msg   = msg_q;
    if (accept) begin
      if (in_i.mode) begin
        push_o.valid = 1'b1;
      end else if (!esc_q) begin
        if (in_i.rx_byte == CH_DLE) begin
          esc_d = 1'b1;
        end else begin
          store = 1'b1;
        end
      end else begin
        esc_d = 1'b0;
        case (in_i.rx_byte)
          CH_DLE: store = 1'b1;
          CH_ENQ: begin
            push_o.valid     = 1'b1;
            push_o.entry.cmd = CMD_ENQ;
          end
          CH_SOH: widx_d = '0;
          CH_ETB: begin
            push_o.valid     = 1'b1;
            push_o.entry.cmd = CMD_ETB;
          end
          CH_ACK0: begin
            push_o.valid     = 1'b1;
            push_o.entry.cmd = CMD_ACK0;
          end
          default: ;
        endcase
      end
    end
    // only the first MSG_LEN entries are ever read back, the rest just count
    if (store && (widx_q < WIDX_W'(RX_DEPTH))) begin
      for (int k = 0; k < MSG_LEN; k++) begin
        if (widx_q == WIDX_W'(k)) begin
          msg_d[k] = in_i.rx_byte;
        end
      end
      widx_d = widx_q + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      widx_q <= '0;
      msg_q  <= '0;
    end else begin
      esc_q  <= esc_d;
      widx_q <= widx_d;
      msg_q  <= msg_d;
    end
  end

  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= WIDX_W'(RX_DEPTH))
    else $error("receive index past store depth");

endmodule

[design/dlelk_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlelk_fifo
// Short command queue between the front decoder and the reply sequencer.
// ----------------------------------------------------------------------------
module dlelk_fifo import dlelk_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_port_t push_i,
  output logic    full_o,
  output q_port_t head_o,
  input  logic    pop_i
);

  q_entry_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_q, rd_q;
  logic [Q_CW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == Q_CW'(Q_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_q + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH))
    else $error("queue count overflow");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("command pushed into full queue");

endmodule

[design/dlelk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlelk_back
// Reply sequencer: walks one queued command byte by byte into the output register.
// ----------------------------------------------------------------------------
module dlelk_back import dlelk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_port_t          head_i,
  output logic             pop_o,
  input  logic [PAY_W-1:0] tx_payload_i,
  dlelk_out_if.source      out_o
);

  logic [STEP_W-1:0]              step_q, step_d;
  logic [MSG_IDX_W-1:0]           pidx;
  logic [STEP_W-1:0]              last_step;
  logic [PAY_BYTES-1:0][7:0]      pay;
  logic                           load;
  logic                           is_last;
  logic                           kind;
  logic [7:0]                     byte_v;
  logic                           vld_q;
  logic                           kind_q;
  logic [7:0]                     byte_q;
  logic                           last_q;

  assign pay       = tx_payload_i;
  assign pidx      = MSG_IDX_W'(step_q - STEP_W'(2));
  assign last_step = cmd_last_step(head_i.entry.cmd);
  assign is_last   = (step_q == last_step);
  assign load      = head_i.valid && (!vld_q || out_o.ready);
  assign pop_o     = load && is_last;
  assign step_d    = is_last ? '0 : step_q + STEP_W'(1);

  always_comb begin
    kind   = 1'b0;
    byte_v = CH_DLE;
    case (head_i.entry.cmd)
      CMD_START: byte_v = (step_q == '0) ? CH_DLE : CH_ENQ;
      CMD_ENQ:   byte_v = (step_q == '0) ? CH_DLE : CH_ACK0;
      CMD_ETB: begin
        if (step_q < STEP_MSG) begin
          kind   = 1'b1;
          byte_v = head_i.entry.msg[step_q[MSG_IDX_W-1:0]];
        end else if (step_q == STEP_MSG) begin
          byte_v = CH_DLE;
        end else begin
          byte_v = CH_ACK1;
        end
      end
      CMD_ACK0: begin
        if (step_q == '0) begin
          byte_v = CH_DLE;
        end else if (step_q == STEP_W'(1)) begin
          byte_v = CH_SOH;
        end else if (step_q < STEP_MSG_P2) begin
          byte_v = pay[pidx];
        end else if (step_q == STEP_MSG_P2) begin
          byte_v = CH_DLE;
        end else begin
          byte_v = CH_ETB;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
        vld_q  <= 1'b1;
      end else if (out_o.ready) begin
        vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind;
      byte_q <= byte_v;
      last_q <= is_last;
    end
  end

  assign out_o.valid    = vld_q;
  assign out_o.out_kind = kind_q;
  assign out_o.out_byte = byte_q;
  assign out_o.last     = last_q;

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> vld_q && last_q)
    else $error("command retired without a final result");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> step_q == '0)
    else $error("sequencer step not rewound");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> step_q <= last_step)
    else $error("sequencer step past end of reply");

endmodule

[design/dle_link_handshake_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_link_handshake_engine
// DLE-escaped link control: decodes line bytes and start requests, emits replies.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         handshake
//  in_i      in   mode, rx_byte                   valid/ready
//  out_o     out  out_kind, out_byte, last        valid/ready
//  cfg       in   cfg_wdata_i (tx_payload, 48b)   cfg_we_i, no wait
//
//  an item is taken whenever the command queue has room; items
//  with no reply also wait while the queue is full
//  the first result of an item comes out through the command queue and the
//  output register, then one result a cycle unless out_o.ready stalls it:
//  2 results for a start, ENQ; MSG_LEN+2 for ETB; MSG_LEN+4 for ACK0 (10 at most)
//  a two-entry command queue and the output register let the front keep
//  taking items while the back is stalled by out_o.ready
//  reset clears control state but not queue storage or output data, no clearing pass
// ----------------------------------------------------------------------------
module dle_link_handshake_engine import dlelk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dlelk_in_if.sink         in_i,
  dlelk_out_if.source      out_o,
  input  logic             cfg_we_i,
  input  logic [PAY_W-1:0] cfg_wdata_i
);

  logic [PAY_W-1:0] tx_payload_q;
  q_port_t          push;
  q_port_t          head;
  logic             full;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_payload_q <= TX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      tx_payload_q <= cfg_wdata_i;
    end
  end

  dlelk_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .full_i (full)
  );

  dlelk_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  dlelk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .tx_payload_i (tx_payload_q),
    .out_o        (out_o)
  );

endmodule

[verif/tb_dle_link_handshake_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dle_link_handshake_engine
// Drives line bytes and start requests into the link engine under varying
// idle and stall patterns, predicts every reply item and checks each one.
// ----------------------------------------------------------------------------
module tb_dle_link_handshake_engine;
  import dlelk_pkg::*;

  localparam logic MODE_LINE  = 1'b0;
  localparam logic MODE_START = 1'b1;
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_RX    = 1'b1;

  localparam int unsigned DELIVER_N = (MSG_LEN > 6) ? 6 :
                                      ((MSG_LEN > RX_DEPTH) ? RX_DEPTH : MSG_LEN);
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STORE_AW = $clog2(RX_DEPTH);

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [PAY_W-1:0] cfg_wdata;

  dlelk_in_if  in_ch ();
  dlelk_out_if out_ch ();

  dle_link_handshake_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state
  logic             link_esc;
  logic [WIDX_W-1:0] link_widx;
  logic [7:0]       link_store [RX_DEPTH];
  logic [PAY_W-1:0] link_payload;

  reply_t reply_q [$];
  reply_t got_exp;
  int     err_count;
  int     items_sent;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  function automatic void store_rx(input logic [7:0] b);
    if (link_widx < WIDX_W'(RX_DEPTH)) begin
      link_store[link_widx[STORE_AW-1:0]] = b;
      link_widx = link_widx + WIDX_W'(1);
    end
  endfunction

  task automatic predict_replies(input logic mode, input logic [7:0] b);
    reply_t burst [$];
    int     k;
    if (mode == MODE_START) begin
      burst.push_back('{KIND_TX, CH_DLE, 1'b0});
      burst.push_back('{KIND_TX, CH_ENQ, 1'b0});
    end else if (!link_esc) begin
      if (b == CH_DLE) link_esc = 1'b1;
      else store_rx(b);
    end else begin
      link_esc = 1'b0;
      case (b)
        CH_DLE: store_rx(b);
        CH_ENQ: begin
          burst.push_back('{KIND_TX, CH_DLE, 1'b0});
          burst.push_back('{KIND_TX, CH_ACK0, 1'b0});
        end
        CH_SOH: link_widx = '0;
        CH_ETB: begin
          for (k = 0; k < DELIVER_N; k++) burst.push_back('{KIND_RX, link_store[k], 1'b0});
          burst.push_back('{KIND_TX, CH_DLE, 1'b0});
          burst.push_back('{KIND_TX, CH_ACK1, 1'b0});
        end
        CH_ACK0: begin
          burst.push_back('{KIND_TX, CH_DLE, 1'b0});
          burst.push_back('{KIND_TX, CH_SOH, 1'b0});
          for (k = 0; k < DELIVER_N; k++) begin
            burst.push_back('{KIND_TX, link_payload[8*k +: 8], 1'b0});
          end
          burst.push_back('{KIND_TX, CH_DLE, 1'b0});
          burst.push_back('{KIND_TX, CH_ETB, 1'b0});
        end
        default: ;
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) reply_q.push_back(burst[i]);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: out_kind %0d out_byte %02h last %0d",
               out_ch.out_kind, out_ch.out_byte, out_ch.last);
        err_count++;
      end else begin
        got_exp = reply_q.pop_front();
        if (out_ch.out_kind !== got_exp.kind) begin
          $error("out_kind expected %0d actual %0d", got_exp.kind, out_ch.out_kind);
          err_count++;
        end
        if (out_ch.out_byte !== got_exp.data) begin
          $error("out_byte expected %02h actual %02h", got_exp.data, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.last !== got_exp.last) begin
          $error("last expected %0d actual %0d", got_exp.last, out_ch.last);
          err_count++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input logic mode, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_replies(mode, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input logic [7:0] b);
    send_item(MODE_LINE, b);
  endtask

  task automatic send_ctrl(input logic [7:0] code);
    send_line(CH_DLE);
    send_line(code);
  endtask

  // data byte with DLE stuffing
  task automatic send_data(input logic [7:0] b);
    if (b == CH_DLE) send_line(CH_DLE);
    send_line(b);
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (reply_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
  endtask

  task automatic write_payload(input logic [PAY_W-1:0] v);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    link_payload = v;
    @(negedge clk_i);
  endtask

  task automatic test_start_request();
    send_item(MODE_START, 8'hFF);
    send_item(MODE_START, 8'h00);
  endtask

  task automatic test_enquiry();
    send_ctrl(CH_ENQ);
  endtask

  // delivery from a never-written store gives zeros
  task automatic test_deliver_empty();
    send_ctrl(CH_ETB);
  endtask

  task automatic test_frame_receive();
    send_ctrl(CH_SOH);
    send_line(8'h00);
    send_line(8'hFF);
    send_ctrl(CH_DLE);
    send_line(8'hA5);
    send_ctrl(CH_ETB);
  endtask

  task automatic test_send_payload();
    send_ctrl(CH_ACK0);
  endtask

  task automatic test_ignored_codes();
    send_ctrl(CH_ACK1);
    send_ctrl(8'hFF);
  endtask

  // start between DLE and its code leaves the escape pending
  task automatic test_start_mid_escape();
    send_line(CH_DLE);
    send_item(MODE_START, 8'h5A);
    send_line(CH_ENQ);
  endtask

  // fill past the end, then try a literal DLE on the full store
  task automatic test_store_full();
    int n;
    logic [7:0] b;
    send_ctrl(CH_SOH);
    for (n = 0; n < RX_DEPTH + 1; n++) begin
      b = 8'($urandom_range(0, 255));
      send_data(b);
    end
    send_ctrl(CH_DLE);
    send_ctrl(CH_ETB);
    send_ctrl(CH_ACK0);
  endtask

  task automatic test_payload_settings();
    write_payload('0);
    send_ctrl(CH_ACK0);
    write_payload('1);
    send_ctrl(CH_ACK0);
    send_item(MODE_START, 8'h33);
    write_payload(PAY_W'({$urandom(), $urandom()}));
    send_ctrl(CH_ACK0);
  endtask

  // receiver holds off while requests keep coming, input must stall
  task automatic test_backpressure();
    int n;
    drain_replies();
    @(posedge clk_i);
    hold_left = 160;
    @(negedge clk_i);
    for (n = 0; n < 2; n++) begin
      send_ctrl(CH_ENQ);
      send_ctrl(CH_ACK0);
    end
    send_item(MODE_START, 8'h81);
    drain_replies();
  endtask

  task automatic test_random_traffic(input int n_items, input int snd, input int rcv);
    int start_cnt;
    int len;
    int j;
    set_idle(snd, rcv);
    start_cnt = items_sent;
    while (items_sent - start_cnt < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_ctrl(CH_SOH);
          len = $urandom_range(0, 8);
          for (j = 0; j < len; j++) send_data(8'($urandom_range(0, 255)));
          send_ctrl(CH_ETB);
        end
        4: send_ctrl(CH_ENQ);
        5: send_ctrl(CH_ACK0);
        6: send_item(MODE_START, 8'($urandom_range(0, 255)));
        7: send_ctrl(8'($urandom_range(0, 255)));
        8: send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        default: begin
          // frame with no opening code
          len = $urandom_range(1, 5);
          for (j = 0; j < len; j++) send_line(8'($urandom_range(0, 255)));
          send_ctrl(CH_ETB);
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_LINE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_ni        = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    hold_left     = 0;
    set_idle(0, 0);
    link_esc     = 1'b0;
    link_widx    = '0;
    link_payload = TX_PAYLOAD_RST;
    foreach (link_store[i]) link_store[i] = 8'h00;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_start_request();
    test_enquiry();
    test_deliver_empty();
    test_frame_receive();
    test_send_payload();
    test_ignored_codes();
    test_start_mid_escape();

    set_idle(63, 0);
    test_store_full();
    set_idle(0, 63);
    test_payload_settings();
    set_idle(24, 24);
    test_backpressure();

    test_random_traffic(6, 24, 24);

    drain_replies();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dlelk_pkg.sv
design/dlelk_if.sv
design/dlelk_front.sv
design/dlelk_fifo.sv
design/dlelk_back.sv
design/dle_link_handshake_engine.sv
verif/tb_dle_link_handshake_engine.sv
